@@ src/ffha_pkg.sv @@
package ffha_pkg;

    // Sizes of the allocator and of its free table.
    localparam int PAGE_BYTES      = 4096;
    localparam int PAGE_BITS       = $clog2(PAGE_BYTES);
    localparam int TABLE_DEPTH     = 64;
    localparam int IDX_BITS        = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS        = IDX_BITS + 1;
    localparam int ADDR_BITS       = 32;
    localparam int WORD_BYTES      = 8;
    localparam int HEADER_BYTES    = 8;
    localparam int MIN_BLOCK_BYTES = 24;

    // Widths of the request fields and of the values derived from them.
    localparam int REQ_BITS   = 24;
    localparam int NEED_BITS  = REQ_BITS + 1;
    localparam int RSIZE_BITS = 26;
    localparam int BYTES_BITS = 13;
    localparam int ORDER_BITS = 4;

    // Result codes.
    typedef enum logic [3:0] {
        ST_FROM_LIST    = 4'd0,
        ST_NEW_PAGE     = 4'd1,
        ST_WHOLE_PAGES  = 4'd2,
        ST_FREED        = 4'd3,
        ST_PAGE_RELEASE = 4'd4,
        ST_WHOLE_FREED  = 4'd5,
        ST_NULL_IGNORED = 4'd6,
        ST_DOUBLE_FREE  = 4'd7,
        ST_TABLE_FULL   = 4'd8,
        ST_OUT_OF_MEM   = 4'd9
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        FS_IDLE,
        FS_DECODE,
        FS_SCAN,
        FS_SHIFT,
        FS_PUSH,
        FS_FINISH
    } fsm_t;

    // One free block: header address and total size.
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] size;
    } tbl_entry_t;

    // Access to the free table, indexes relative to the head.
    typedef struct packed {
        logic                rd_en;
        logic [IDX_BITS-1:0] rd_idx;
        logic                wr_en;
        logic [IDX_BITS-1:0] wr_idx;
        logic                push;
        tbl_entry_t          wr_data;
    } tbl_cmd_t;

    // Smallest page order whose span covers the size, saturating at 15.
    function automatic logic [ORDER_BITS-1:0] order_of(input logic [RSIZE_BITS-1:0] size);
        logic [ORDER_BITS-1:0] r;
        logic [RSIZE_BITS+1:0] lim;
        r = {ORDER_BITS{1'b1}};
        for (int o = 15; o >= 0; o--)
        begin
            lim = (RSIZE_BITS + 2)'(PAGE_BYTES) << o;
            if (lim >= {2'b00, size})
            begin
                r = ORDER_BITS'(o);
            end
        end
        return r;
    endfunction

endpackage

@@ src/ffha_table.sv @@
module ffha_table
    import ffha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tbl_cmd_t   cmd,
    output tbl_entry_t rd_data
);

    tbl_entry_t          mem [TABLE_DEPTH];
    tbl_entry_t          rd_data_reg;
    logic [IDX_BITS-1:0] head_reg;
    logic [IDX_BITS-1:0] head_next;
    logic [IDX_BITS-1:0] rd_phys;
    logic [IDX_BITS-1:0] wr_phys;

    // Logical indexes count from the head; a push writes just before it.
    assign rd_phys   = head_reg + cmd.rd_idx;
    assign wr_phys   = head_reg + cmd.wr_idx;
    assign head_next = cmd.push ? head_reg - IDX_BITS'(1) : head_reg;

    // Head pointer of the circular table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
        end
    end

    // Storage with one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_phys] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_phys];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/first_fit_heap_allocator_top.sv @@
// Steps: decode, then a scan with one table read per entry and, after an allocation from
// the table, a shift that closes the gap, then a push when a block goes back to the table
// and a finish that offers the result; whole-page and rejected requests skip the scan.
// One request is in work at a time; the next may enter while a result waits.
// Reset (rst_n, asynchronous) empties the table; its storage is not cleared.
module first_fit_heap_allocator_top
    import ffha_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic                         kind,
    input  logic [REQ_BITS-1:0]          request_size,
    input  logic [ADDR_BITS-1:0]         block_address,
    input  logic signed [RSIZE_BITS-1:0] recorded_size,
    input  logic [ADDR_BITS-1:0]         spare_page,
    input  logic                         spare_valid,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [3:0]                   status,
    output logic [ADDR_BITS-1:0]         data_address,
    output logic [BYTES_BITS-1:0]        block_bytes,
    output logic [ADDR_BITS-1:0]         page_address,
    output logic [ORDER_BITS-1:0]        page_order
);

    fsm_t state_reg, state_next;

    // Captured request.
    logic                  kind_reg, kind_next;
    logic [REQ_BITS-1:0]   rsz_reg, rsz_next;
    logic [ADDR_BITS-1:0]  baddr_reg, baddr_next;
    logic [RSIZE_BITS-1:0] rec_reg, rec_next;
    logic [ADDR_BITS-1:0]  spare_reg, spare_next;
    logic                  spok_reg, spok_next;

    // Table bookkeeping and walk counters.
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [CNT_BITS-1:0]  rdk_reg, rdk_next;
    logic [CNT_BITS-1:0]  wn_reg, wn_next;
    logic                 pend_reg, pend_next;
    logic [ADDR_BITS-1:0] ca_reg, ca_next;
    logic [ADDR_BITS-1:0] cs_reg, cs_next;
    logic [ADDR_BITS-1:0] fa_reg, fa_next;
    logic [ADDR_BITS-1:0] fs_reg, fs_next;
    logic [ADDR_BITS-1:0] pa_reg, pa_next;
    logic [ADDR_BITS-1:0] ps_reg, ps_next;

    // Result being built and result on offer.
    status_t               rs_status_reg, rs_status_next;
    logic [ADDR_BITS-1:0]  rs_data_reg, rs_data_next;
    logic [BYTES_BITS-1:0] rs_bytes_reg, rs_bytes_next;
    logic [ADDR_BITS-1:0]  rs_page_reg, rs_page_next;
    logic [ORDER_BITS-1:0] rs_order_reg, rs_order_next;
    logic                  ov_reg, ov_next;
    status_t               o_status_reg, o_status_next;
    logic [ADDR_BITS-1:0]  o_data_reg, o_data_next;
    logic [BYTES_BITS-1:0] o_bytes_reg, o_bytes_next;
    logic [ADDR_BITS-1:0]  o_page_reg, o_page_next;
    logic [ORDER_BITS-1:0] o_order_reg, o_order_next;

    tbl_cmd_t   cmd;
    tbl_entry_t ent;

    logic                  req_acc;
    logic                  out_free;
    logic [NEED_BITS-1:0]  need_raw;
    logic [NEED_BITS-1:0]  need_rnd;
    logic [NEED_BITS-1:0]  need;
    logic                  need_big;
    logic [ADDR_BITS-1:0]  need_a;
    logic [ADDR_BITS-1:0]  hdr;
    logic                  bad_hdr;
    logic [RSIZE_BITS-1:0] fsize;
    logic                  fsize_big;
    logic                  fits;
    logic                  merge_lo;
    logic                  merge_hi;
    logic                  walk_end;
    logic                  rd_more;
    logic [BYTES_BITS-1:0] page_rem;
    logic                  page_split;
    logic [ADDR_BITS-1:0]  base;
    logic [ADDR_BITS-1:0]  rem;
    logic                  release_pg;

    ffha_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_data (ent)
    );

    assign req_acc  = req_valid && !req_stall;
    assign out_free = !ov_reg || !rsp_stall;

    // Allocation size: header added, rounded to a word, raised to the minimum.
    assign need_raw = NEED_BITS'(rsz_reg) + NEED_BITS'(HEADER_BYTES);
    assign need_rnd = (need_raw + NEED_BITS'(WORD_BYTES - 1))
                      & ~NEED_BITS'(WORD_BYTES - 1);
    assign need     = (need_rnd < NEED_BITS'(MIN_BLOCK_BYTES))
                      ? NEED_BITS'(MIN_BLOCK_BYTES) : need_rnd;
    assign need_big = need >= NEED_BITS'(PAGE_BYTES);
    assign need_a   = ADDR_BITS'(need);

    // Free checks: header on the same page, and the recorded size as a length.
    assign hdr       = baddr_reg - ADDR_BITS'(HEADER_BYTES);
    assign bad_hdr   = (baddr_reg == '0)
                       || (hdr[ADDR_BITS-1:PAGE_BITS] != baddr_reg[ADDR_BITS-1:PAGE_BITS]);
    assign fsize     = RSIZE_BITS'(0) - rec_reg;
    assign fsize_big = fsize >= RSIZE_BITS'(PAGE_BYTES);

    // Tests on the entry that the table returned this cycle.
    assign fits     = ent.size >= need_a;
    assign merge_lo = (ent.addr + ent.size) == ca_reg;
    assign merge_hi = (ca_reg + cs_reg) == ent.addr;
    assign rd_more  = rdk_reg < count_reg;
    assign walk_end = !pend_reg && !rd_more;

    // Outcomes at the end of a walk.
    assign page_rem   = BYTES_BITS'(PAGE_BYTES) - need[BYTES_BITS-1:0];
    assign page_split = (page_rem >= BYTES_BITS'(MIN_BLOCK_BYTES))
                        && (count_reg < CNT_BITS'(TABLE_DEPTH));
    assign base       = spare_reg & ~ADDR_BITS'(PAGE_BYTES - 1);
    assign rem        = fs_reg - need_a;
    assign release_pg = (cs_reg == ADDR_BITS'(PAGE_BYTES)) && (ca_reg[PAGE_BITS-1:0] == '0);

    assign req_stall = (state_reg != FS_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = FS_DECODE;
                end
            end
            FS_DECODE:
            begin
                if (!kind_reg)
                begin
                    state_next = need_big ? FS_FINISH : FS_SCAN;
                end
                else if (bad_hdr || !rec_reg[RSIZE_BITS-1] || fsize_big)
                begin
                    state_next = FS_FINISH;
                end
                else
                begin
                    state_next = FS_SCAN;
                end
            end
            FS_SCAN:
            begin
                if (!kind_reg)
                begin
                    if (pend_reg && fits)
                    begin
                        state_next = FS_SHIFT;
                    end
                    else if (walk_end)
                    begin
                        state_next = (spok_reg && page_split) ? FS_PUSH : FS_FINISH;
                    end
                end
                else if (walk_end)
                begin
                    state_next = (release_pg || wn_reg >= CNT_BITS'(TABLE_DEPTH))
                                 ? FS_FINISH : FS_PUSH;
                end
            end
            FS_SHIFT:
            begin
                if (walk_end)
                begin
                    state_next = (rem >= ADDR_BITS'(MIN_BLOCK_BYTES)) ? FS_PUSH : FS_FINISH;
                end
            end
            FS_PUSH:
            begin
                state_next = FS_FINISH;
            end
            FS_FINISH:
            begin
                if (out_free)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    // Datapath, table access and results.
    always_comb
    begin
        kind_next      = kind_reg;
        rsz_next       = rsz_reg;
        baddr_next     = baddr_reg;
        rec_next       = rec_reg;
        spare_next     = spare_reg;
        spok_next      = spok_reg;
        count_next     = count_reg;
        rdk_next       = rdk_reg;
        wn_next        = wn_reg;
        pend_next      = pend_reg;
        ca_next        = ca_reg;
        cs_next        = cs_reg;
        fa_next        = fa_reg;
        fs_next        = fs_reg;
        pa_next        = pa_reg;
        ps_next        = ps_reg;
        rs_status_next = rs_status_reg;
        rs_data_next   = rs_data_reg;
        rs_bytes_next  = rs_bytes_reg;
        rs_page_next   = rs_page_reg;
        rs_order_next  = rs_order_reg;
        ov_next        = ov_reg && rsp_stall;
        o_status_next  = o_status_reg;
        o_data_next    = o_data_reg;
        o_bytes_next   = o_bytes_reg;
        o_page_next    = o_page_reg;
        o_order_next   = o_order_reg;
        cmd            = '0;

        unique case (state_reg)
            FS_IDLE:
            begin
                if (req_acc)
                begin
                    kind_next  = kind;
                    rsz_next   = request_size;
                    baddr_next = block_address;
                    rec_next   = recorded_size;
                    spare_next = spare_page;
                    spok_next  = spare_valid;
                end
            end
            FS_DECODE:
            begin
                rs_status_next = ST_FROM_LIST;
                rs_data_next   = '0;
                rs_bytes_next  = '0;
                rs_page_next   = '0;
                rs_order_next  = '0;
                rdk_next       = '0;
                wn_next        = '0;
                pend_next      = 1'b0;
                if (!kind_reg)
                begin
                    if (need_big)
                    begin
                        rs_status_next = ST_WHOLE_PAGES;
                        rs_order_next  = order_of(RSIZE_BITS'(need));
                    end
                end
                else if (bad_hdr)
                begin
                    rs_status_next = ST_NULL_IGNORED;
                end
                else if (!rec_reg[RSIZE_BITS-1])
                begin
                    rs_status_next = ST_DOUBLE_FREE;
                end
                else if (fsize_big)
                begin
                    rs_status_next = ST_WHOLE_FREED;
                    rs_page_next   = hdr;
                    rs_order_next  = order_of(fsize);
                end
                else
                begin
                    ca_next = hdr;
                    cs_next = ADDR_BITS'(fsize);
                end
            end
            FS_SCAN:
            begin
                // One read issued per cycle, the previous one checked.
                cmd.rd_en  = rd_more;
                cmd.rd_idx = rdk_reg[IDX_BITS-1:0];
                rdk_next   = rd_more ? rdk_reg + CNT_BITS'(1) : rdk_reg;
                pend_next  = rd_more;
                if (!kind_reg)
                begin
                    if (pend_reg && fits)
                    begin
                        // First fit: close the gap from the entry after it.
                        fa_next   = ent.addr;
                        fs_next   = ent.size;
                        wn_next   = rdk_reg - CNT_BITS'(1);
                        rdk_next  = rdk_reg;
                        pend_next = 1'b0;
                    end
                    else if (walk_end)
                    begin
                        if (spok_reg)
                        begin
                            rs_status_next = ST_NEW_PAGE;
                            rs_data_next   = base + ADDR_BITS'(HEADER_BYTES);
                            rs_page_next   = base;
                            pa_next        = base + need_a;
                            ps_next        = ADDR_BITS'(page_rem);
                            rs_bytes_next  = page_split ? need[BYTES_BITS-1:0]
                                                        : BYTES_BITS'(PAGE_BYTES);
                        end
                        else
                        begin
                            rs_status_next = ST_OUT_OF_MEM;
                        end
                    end
                end
                else
                begin
                    // Merge with neighbours, compacting the survivors.
                    if (pend_reg)
                    begin
                        if (merge_lo)
                        begin
                            cs_next = cs_reg + ent.size;
                            ca_next = ent.addr;
                        end
                        else if (merge_hi)
                        begin
                            cs_next = cs_reg + ent.size;
                        end
                        else
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_idx  = wn_reg[IDX_BITS-1:0];
                            cmd.wr_data = ent;
                            wn_next     = wn_reg + CNT_BITS'(1);
                        end
                    end
                    if (walk_end)
                    begin
                        count_next = wn_reg;
                        pa_next    = ca_reg;
                        ps_next    = cs_reg;
                        if (release_pg)
                        begin
                            rs_status_next = ST_PAGE_RELEASE;
                            rs_page_next   = ca_reg;
                            rs_bytes_next  = cs_reg[BYTES_BITS-1:0];
                        end
                        else if (wn_reg >= CNT_BITS'(TABLE_DEPTH))
                        begin
                            rs_status_next = ST_TABLE_FULL;
                        end
                        else
                        begin
                            rs_status_next = ST_FREED;
                            rs_bytes_next  = cs_reg[BYTES_BITS-1:0];
                        end
                    end
                end
            end
            FS_SHIFT:
            begin
                // Move each later entry one place towards the head.
                cmd.rd_en  = rd_more;
                cmd.rd_idx = rdk_reg[IDX_BITS-1:0];
                rdk_next   = rd_more ? rdk_reg + CNT_BITS'(1) : rdk_reg;
                pend_next  = rd_more;
                if (pend_reg)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_idx  = wn_reg[IDX_BITS-1:0];
                    cmd.wr_data = ent;
                    wn_next     = wn_reg + CNT_BITS'(1);
                end
                if (walk_end)
                begin
                    count_next     = count_reg - CNT_BITS'(1);
                    rs_status_next = ST_FROM_LIST;
                    rs_data_next   = fa_reg + ADDR_BITS'(HEADER_BYTES);
                    pa_next        = fa_reg + need_a;
                    ps_next        = rem;
                    rs_bytes_next  = (rem >= ADDR_BITS'(MIN_BLOCK_BYTES))
                                     ? need[BYTES_BITS-1:0] : fs_reg[BYTES_BITS-1:0];
                end
            end
            FS_PUSH:
            begin
                cmd.wr_en        = 1'b1;
                cmd.wr_idx       = '1;
                cmd.push         = 1'b1;
                cmd.wr_data.addr = pa_reg;
                cmd.wr_data.size = ps_reg;
                count_next       = count_reg + CNT_BITS'(1);
            end
            FS_FINISH:
            begin
                if (out_free)
                begin
                    ov_next       = 1'b1;
                    o_status_next = rs_status_reg;
                    o_data_next   = rs_data_reg;
                    o_bytes_next  = rs_bytes_reg;
                    o_page_next   = rs_page_reg;
                    o_order_next  = rs_order_reg;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            count_reg <= '0;
            rdk_reg   <= '0;
            wn_reg    <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rdk_reg   <= rdk_next;
            wn_reg    <= wn_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        rsz_reg       <= rsz_next;
        baddr_reg     <= baddr_next;
        rec_reg       <= rec_next;
        spare_reg     <= spare_next;
        spok_reg      <= spok_next;
        ca_reg        <= ca_next;
        cs_reg        <= cs_next;
        fa_reg        <= fa_next;
        fs_reg        <= fs_next;
        pa_reg        <= pa_next;
        ps_reg        <= ps_next;
        rs_status_reg <= rs_status_next;
        rs_data_reg   <= rs_data_next;
        rs_bytes_reg  <= rs_bytes_next;
        rs_page_reg   <= rs_page_next;
        rs_order_reg  <= rs_order_next;
        o_status_reg  <= o_status_next;
        o_data_reg    <= o_data_next;
        o_bytes_reg   <= o_bytes_next;
        o_page_reg    <= o_page_next;
        o_order_reg   <= o_order_next;
    end

    assign rsp_valid    = ov_reg;
    assign status       = 4'(o_status_reg);
    assign data_address = o_data_reg;
    assign block_bytes  = o_bytes_reg;
    assign page_address = o_page_reg;
    assign page_order   = o_order_reg;

    // The table never holds more entries than it has rows.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(TABLE_DEPTH))
        else $error("free table count out of range");

    // An accepted transaction is decoded in the next cycle.
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> state_reg == FS_DECODE)
        else $error("accepted transaction not decoded");

    // Compaction writes stay inside the occupied part of the table.
    a_write_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && !cmd.push) |-> (CNT_BITS'(cmd.wr_idx) < count_reg))
        else $error("table write beyond occupied entries");

    // A push only happens with room in the table.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> count_reg < CNT_BITS'(TABLE_DEPTH))
        else $error("push into a full table");

    // A new result appears only after the finishing state.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == FS_FINISH))
        else $error("result raised outside finish");

endmodule

@@ test/ffha_checker.sv @@
module ffha_checker
    import ffha_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic                         req_stall,
    input  logic                         kind,
    input  logic [REQ_BITS-1:0]          request_size,
    input  logic [ADDR_BITS-1:0]         block_address,
    input  logic signed [RSIZE_BITS-1:0] recorded_size,
    input  logic [ADDR_BITS-1:0]         spare_page,
    input  logic                         spare_valid,
    input  logic                         rsp_valid,
    input  logic                         rsp_stall,
    input  logic [3:0]                   status,
    input  logic [ADDR_BITS-1:0]         data_address,
    input  logic [BYTES_BITS-1:0]        block_bytes,
    input  logic [ADDR_BITS-1:0]         page_address,
    input  logic [ORDER_BITS-1:0]        page_order,
    output int                           errors,
    output int                           pending
);

    typedef struct {
        status_t               st;
        logic [ADDR_BITS-1:0]  data;
        logic [BYTES_BITS-1:0] bytes;
        logic [ADDR_BITS-1:0]  page;
        logic [ORDER_BITS-1:0] order;
    } grant_t;

    localparam logic [ADDR_BITS-1:0] PG_BASE_MASK = ~ADDR_BITS'(PAGE_BYTES - 1);

    // Our own copy of the free table.
    logic [ADDR_BITS-1:0] free_addr [TABLE_DEPTH];
    logic [ADDR_BITS-1:0] free_size [TABLE_DEPTH];
    int                   free_num;
    grant_t               awaited [$];

    assign pending = awaited.size();

    function automatic logic [ORDER_BITS-1:0] page_order_for(longint unsigned size);
        int o;
        o = 0;
        while ((longint'(PAGE_BYTES) << o) < size && o < 15)
        begin
            o++;
        end
        return ORDER_BITS'(o);
    endfunction

    task automatic table_push(logic [ADDR_BITS-1:0] a, logic [ADDR_BITS-1:0] s);
        for (int i = free_num; i > 0; i--)
        begin
            free_addr[i] = free_addr[i-1];
            free_size[i] = free_size[i-1];
        end
        free_addr[0] = a;
        free_size[0] = s;
        free_num++;
    endtask

    task automatic table_remove(int k);
        for (int i = k; i < free_num - 1; i++)
        begin
            free_addr[i] = free_addr[i+1];
            free_size[i] = free_size[i+1];
        end
        free_num--;
    endtask

    // Works out the grant or release that one request should produce.
    task automatic predict_request(output grant_t g);
        longint unsigned      need;
        logic [ADDR_BITS-1:0] a, s, base, hdr, ca, cs;
        logic [RSIZE_BITS-1:0] rs;
        longint unsigned      size;
        bit                   found, keep;
        int                   n;
        g = '{ST_FROM_LIST, '0, '0, '0, '0};
        if (kind == 1'b0)
        begin
            need = longint'(request_size) + HEADER_BYTES;
            need = (need + WORD_BYTES - 1) & ~longint'(WORD_BYTES - 1);
            if (need < MIN_BLOCK_BYTES)
            begin
                need = MIN_BLOCK_BYTES;
            end
            if (need >= PAGE_BYTES)
            begin
                g.st = ST_WHOLE_PAGES;
                g.order = page_order_for(need);
            end
            else
            begin
                found = 0;
                for (int k = 0; k < free_num; k++)
                begin
                    if (free_size[k] >= need)
                    begin
                        a = free_addr[k];
                        s = free_size[k];
                        table_remove(k);
                        if (s - need >= MIN_BLOCK_BYTES)
                        begin
                            table_push(a + ADDR_BITS'(need), s - ADDR_BITS'(need));
                            g.bytes = BYTES_BITS'(need);
                        end
                        else
                        begin
                            g.bytes = BYTES_BITS'(s);
                        end
                        g.data = a + HEADER_BYTES;
                        g.st = ST_FROM_LIST;
                        found = 1;
                        break;
                    end
                end
                if (!found)
                begin
                    if (spare_valid)
                    begin
                        base = spare_page & PG_BASE_MASK;
                        if (PAGE_BYTES - need >= MIN_BLOCK_BYTES && free_num < TABLE_DEPTH)
                        begin
                            table_push(base + ADDR_BITS'(need),
                                       ADDR_BITS'(PAGE_BYTES - need));
                            g.bytes = BYTES_BITS'(need);
                        end
                        else
                        begin
                            g.bytes = BYTES_BITS'(PAGE_BYTES);
                        end
                        g.st = ST_NEW_PAGE;
                        g.data = base + HEADER_BYTES;
                        g.page = base;
                    end
                    else
                    begin
                        g.st = ST_OUT_OF_MEM;
                    end
                end
            end
        end
        else
        begin
            rs = recorded_size;
            hdr = block_address - HEADER_BYTES;
            if (block_address == '0
                || (hdr & PG_BASE_MASK) != (block_address & PG_BASE_MASK))
            begin
                g.st = ST_NULL_IGNORED;
            end
            else if (!rs[RSIZE_BITS-1])
            begin
                g.st = ST_DOUBLE_FREE;
            end
            else
            begin
                size = (longint'(1) << RSIZE_BITS) - longint'(rs);
                if (size >= PAGE_BYTES)
                begin
                    g.st = ST_WHOLE_FREED;
                    g.page = hdr;
                    g.order = page_order_for(size);
                end
                else
                begin
                    // Coalesce with neighbours on either side, compacting in place.
                    ca = hdr;
                    cs = ADDR_BITS'(size);
                    n = 0;
                    for (int k = 0; k < free_num; k++)
                    begin
                        a = free_addr[k];
                        s = free_size[k];
                        keep = 1;
                        if (a + s == ca)
                        begin
                            keep = 0;
                            cs = cs + s;
                            ca = a;
                        end
                        else if (ca + cs == a)
                        begin
                            keep = 0;
                            cs = cs + s;
                        end
                        if (keep)
                        begin
                            free_addr[n] = a;
                            free_size[n] = s;
                            n++;
                        end
                    end
                    free_num = n;
                    if (cs == PAGE_BYTES && (ca & ~PG_BASE_MASK) == '0)
                    begin
                        g.st = ST_PAGE_RELEASE;
                        g.page = ca;
                        g.bytes = BYTES_BITS'(cs);
                    end
                    else if (free_num >= TABLE_DEPTH)
                    begin
                        g.st = ST_TABLE_FULL;
                    end
                    else
                    begin
                        table_push(ca, cs);
                        g.st = ST_FREED;
                        g.bytes = BYTES_BITS'(cs);
                    end
                end
            end
        end
    endtask

    // Predict on each accepted request and compare each accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        grant_t g, e;
        if (!rst_n)
        begin
            free_num = 0;
            errors = 0;
            awaited.delete();
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predict_request(g);
                awaited.push_back(g);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: unexpected transaction, status %0d", $time, status);
                    errors++;
                end
                else
                begin
                    e = awaited.pop_front();
                    if (status != e.st)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                        errors++;
                    end
                    if (data_address != e.data)
                    begin
                        $display("%0t: data_address expected %h actual %h",
                                 $time, e.data, data_address);
                        errors++;
                    end
                    if (block_bytes != e.bytes)
                    begin
                        $display("%0t: block_bytes expected %0d actual %0d",
                                 $time, e.bytes, block_bytes);
                        errors++;
                    end
                    if (page_address != e.page)
                    begin
                        $display("%0t: page_address expected %h actual %h",
                                 $time, e.page, page_address);
                        errors++;
                    end
                    if (page_order != e.order)
                    begin
                        $display("%0t: page_order expected %0d actual %0d",
                                 $time, e.order, page_order);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

@@ test/tb_first_fit_heap_allocator_top.sv @@
module tb_first_fit_heap_allocator_top;
    import ffha_pkg::*;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         req_valid = 1'b0;
    logic                         req_stall;
    logic                         kind = 1'b0;
    logic [REQ_BITS-1:0]          request_size = '0;
    logic [ADDR_BITS-1:0]         block_address = '0;
    logic signed [RSIZE_BITS-1:0] recorded_size = '0;
    logic [ADDR_BITS-1:0]         spare_page = '0;
    logic                         spare_valid = 1'b0;
    logic                         rsp_valid;
    logic                         rsp_stall = 1'b0;
    logic [3:0]                   status;
    logic [ADDR_BITS-1:0]         data_address;
    logic [BYTES_BITS-1:0]        block_bytes;
    logic [ADDR_BITS-1:0]         page_address;
    logic [ORDER_BITS-1:0]        page_order;
    int                           errors;
    int                           pending;

    localparam int IDLE_LIMIT = 4000;

    // Blocks currently held by the caller, kept so that they can be freed later.
    logic [ADDR_BITS-1:0]  live_addr [$];
    logic [BYTES_BITS-1:0] live_bytes [$];
    logic [ADDR_BITS-1:0]  next_page = 32'h0010_0000;
    int                    results_seen = 0;
    int                    idle_cycles = 0;
    bit                    sender_quiet = 0;
    bit                    receiver_quiet = 0;

    always #4 clk = ~clk;

    first_fit_heap_allocator_top dut (.*);

    ffha_checker u_checker (.*);

    // Record every granted block.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen <= results_seen + 1;
            if (status == ST_FROM_LIST || status == ST_NEW_PAGE)
            begin
                live_addr.push_back(data_address);
                live_bytes.push_back(block_bytes);
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random stalls, quiet stretches and one long hold-off.
    initial
    begin
        int  n;
        bit  held;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            n = receiver_quiet ? 0 : $urandom_range(0, 7);
            if (!held && results_seen >= 400)
            begin
                n = 300;
                held = 1;
            end
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    task automatic send_request(bit k, logic [REQ_BITS-1:0] rsz, logic [ADDR_BITS-1:0] ba,
                                logic signed [RSIZE_BITS-1:0] rec, logic [ADDR_BITS-1:0] sp,
                                bit sv);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid     <= 1'b1;
        kind          <= k;
        request_size  <= rsz;
        block_address <= ba;
        recorded_size <= rec;
        spare_page    <= sp;
        spare_valid   <= sv;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic alloc_request(logic [REQ_BITS-1:0] rsz);
        send_request(1'b0, rsz, $urandom, RSIZE_BITS'($urandom), next_page, 1'b1);
        next_page = next_page + PAGE_BYTES;
    endtask

    // Free a random live block with its proper header value.
    task automatic free_live_block();
        int i;
        logic [ADDR_BITS-1:0]  a;
        logic [BYTES_BITS-1:0] b;
        i = $urandom_range(0, live_addr.size() - 1);
        a = live_addr[i];
        b = live_bytes[i];
        live_addr.delete(i);
        live_bytes.delete(i);
        send_request(1'b1, REQ_BITS'($urandom), a, -RSIZE_BITS'(b), $urandom,
                     1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int r;
        logic signed [RSIZE_BITS-1:0] rec;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: out of memory on an empty table, then field extremes.
        send_request(1'b0, 24'd16, '0, '0, '0, 1'b0);
        alloc_request(24'd0);
        alloc_request(24'd16777207);
        alloc_request(24'd4088);
        alloc_request(24'd4080);
        alloc_request(24'd100);
        alloc_request(24'd200);
        send_request(1'b0, 24'd3000, '0, '0, 32'hFFFF_FFFF, 1'b1);
        // Frees: null, header on the previous page, double free, whole pages.
        send_request(1'b1, '0, '0, -26'sd32, '0, 1'b0);
        send_request(1'b1, '0, 32'h0020_0000, -26'sd32, '0, 1'b0);
        send_request(1'b1, '0, 32'h0000_0004, -26'sd32, '0, 1'b0);
        send_request(1'b1, '0, 32'h0020_0010, 26'sd0, '0, 1'b0);
        send_request(1'b1, '0, 32'h0020_0010, 26'sd16777216, '0, 1'b0);
        send_request(1'b1, '0, 32'h0030_0008, -26'sd8192, '0, 1'b0);
        send_request(1'b1, '0, 32'h0030_0008, -26'sd16777216, '0, 1'b0);
        send_request(1'b1, '0, 32'h0030_0008, -26'sd4096, '0, 1'b0);
        // Misaligned whole page and an oversized merge.
        send_request(1'b1, '0, 32'h0050_0808, -26'sd2048, '0, 1'b0);
        send_request(1'b1, '0, 32'h0050_1008, -26'sd2048, '0, 1'b0);
        send_request(1'b1, '0, 32'h0050_1808, -26'sd1024, '0, 1'b0);
        while (live_addr.size() > 0)
        begin
            free_live_block();
        end

        // Fill the table with separated blocks until it overflows.
        for (int k = 0; k < 66; k++)
        begin
            send_request(1'b1, '0, 32'h4000_0008 + 64 * k, -26'sd32, '0, 1'b0);
        end
        alloc_request(24'd100);
        alloc_request(24'd24);

        // Random traffic, mostly well-formed allocate and free sequences.
        for (int i = 0; i < 1250; i++)
        begin
            if (i % 128 == 0)
            begin
                sender_quiet = ($urandom_range(0, 3) == 0);
                receiver_quiet = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                alloc_request(REQ_BITS'($urandom_range(0, 16777207)));
            end
            else if (r < 6)
            begin
                send_request(1'b0, REQ_BITS'($urandom_range(0, 1000)), $urandom,
                             RSIZE_BITS'($urandom), $urandom, 1'($urandom_range(0, 1)));
            end
            else if (r < 14)
            begin
                rec = RSIZE_BITS'($urandom_range(0, 33554432) - 16777216);
                if ($urandom_range(0, 1))
                begin
                    rec = -RSIZE_BITS'($urandom_range(8, 4200));
                end
                send_request(1'b1, REQ_BITS'($urandom), $urandom, rec, $urandom,
                             1'($urandom_range(0, 1)));
            end
            else if (r < 55 && live_addr.size() > 0)
            begin
                free_live_block();
            end
            else
            begin
                alloc_request(REQ_BITS'($urandom_range(0, (r % 10 == 0) ? 4088 : 400)));
            end
        end
        sender_quiet = 0;
        req_valid <= 1'b0;

        // Drain, then allow for work still in progress.
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
